// ===== hw/rtl/proxy_scan_result_cache_macros.svh =====
// -----------------------------------------------------------------------------
// proxy_scan_result_cache_macros
// assertion macros shared by the cache modules, empty for synthesis
// -----------------------------------------------------------------------------
`ifndef PROXY_SCAN_RESULT_CACHE_MACROS_SVH
`define PROXY_SCAN_RESULT_CACHE_MACROS_SVH

`ifndef SYNTHESIS

// checked on every rising edge outside reset
`define PSRC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("proxy scan result cache assertion failed");

// checked on every rising edge, reset included
`define PSRC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("proxy scan result cache assertion failed");

`else

`define PSRC_ASSERT(label, clk, rst, prop)
`define PSRC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hw/rtl/psrc_pkg.sv =====
// -----------------------------------------------------------------------------
// psrc_pkg
// types and constants of the proxy scan result cache
// -----------------------------------------------------------------------------
package psrc_pkg;

   localparam int STATUS_W = 3;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int KIND_W   = 4;
   localparam int TIME_W   = 64;
   localparam int CFG_W    = 7;
   localparam int SLOT_W   = 6;
   localparam int NUM_CLASS = 5;

   // operation codes
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_PICK = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CLOSED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DENIED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OPEN     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FILTERED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd5;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
      logic [PORT_W-1:0]   port;
      logic [KIND_W-1:0]   kind;
      logic [TIME_W-1:0]   stamp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic clear;   // write one zero entry of the reset sweep
      logic load;    // capture the request item and restart the scan
      logic scan;    // issue the next slot read
      logic emit;    // write back the chosen slot and load the response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic scan_done;
      logic out_busy;
   } sts_type;

endpackage

// ===== hw/rtl/psrc_ctrl.sv =====
// -----------------------------------------------------------------------------
// psrc_ctrl
// sequencer: reset sweep, slot scan, write back and response hand-off
// -----------------------------------------------------------------------------
`include "proxy_scan_result_cache_macros.svh"

module psrc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  psrc_pkg::sts_type sts,
   output psrc_pkg::cmd_type cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_WRITE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            // hold the result until the output register is free
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `PSRC_ASSERT(a_scan_exit_done, clock, reset,
      (state_ff == S_SCAN && state_in != S_SCAN) |-> sts.scan_done)
   `PSRC_ASSERT(a_emit_output_free, clock, reset, cmd.emit |-> !sts.out_busy)
   `PSRC_ASSERT(a_load_starts_scan, clock, reset,
      cmd.load |=> (state_ff == S_SCAN))

endmodule

// ===== hw/rtl/psrc_datapath.sv =====
// -----------------------------------------------------------------------------
// psrc_datapath
// entry memory, scan counter, victim and match trackers, response register
// -----------------------------------------------------------------------------
`include "proxy_scan_result_cache_macros.svh"

module psrc_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  psrc_pkg::cmd_type               cmd,
   output psrc_pkg::sts_type               sts,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psrc_pkg::CFG_W-1:0]      csr_entries_in_use,
   input  logic                            req_op,
   input  logic [psrc_pkg::STATUS_W-1:0]   req_put_status,
   input  logic [psrc_pkg::ADDR_W-1:0]     req_ip_address,
   input  logic [psrc_pkg::PORT_W-1:0]     req_tcp_port,
   input  logic [psrc_pkg::KIND_W-1:0]     req_proxy_kind,
   input  logic [psrc_pkg::TIME_W-1:0]     req_now_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [psrc_pkg::STATUS_W-1:0]   rsp_found_status,
   output logic [psrc_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                            rsp_hit
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int NW = (CW > psrc_pkg::CFG_W) ? CW : psrc_pkg::CFG_W;
   localparam int NC = psrc_pkg::NUM_CLASS;

   // configuration
   logic [psrc_pkg::CFG_W-1:0] cfg_ff;
   logic [NW-1:0]              cfg_wide;
   logic [CW-1:0]              used_in;
   logic [CW-1:0]              used_ff;

   // captured item
   logic                          op_ff;
   psrc_pkg::entry_type           item_ff;

   // memory and read pipeline
   psrc_pkg::entry_type mem [DEPTH];
   psrc_pkg::entry_type rd_data_ff;
   logic [IW-1:0]       clr_cnt_ff;
   logic [CW-1:0]       rd_cnt_ff;
   logic                rv_ff;
   logic [IW-1:0]       ri_ff;
   logic                issue;
   logic                mem_we;
   logic [IW-1:0]       mem_wa;
   psrc_pkg::entry_type mem_wd;

   // trackers
   logic                empty_found_ff, empty_found_in;
   logic [IW-1:0]       empty_idx_ff, empty_idx_in;
   logic                cls_found_ff [NC];
   logic                cls_found_in [NC];
   logic [IW-1:0]       cls_idx_ff [NC];
   logic [IW-1:0]       cls_idx_in [NC];
   logic [psrc_pkg::TIME_W-1:0] cls_time_ff [NC];
   logic [psrc_pkg::TIME_W-1:0] cls_time_in [NC];
   logic                all_found_ff, all_found_in;
   logic [IW-1:0]       all_idx_ff, all_idx_in;
   logic [psrc_pkg::TIME_W-1:0] all_time_ff, all_time_in;
   logic                pick_found_ff, pick_found_in;
   logic [IW-1:0]       pick_idx_ff, pick_idx_in;
   psrc_pkg::entry_type pick_word_ff, pick_word_in;

   // scan step helpers
   logic                in_class;
   logic [2:0]          cls_sel;
   logic                key_match;

   // write back selection
   logic                wr_ok;
   logic [IW-1:0]       tgt_idx;
   psrc_pkg::entry_type wr_word;
   logic [IW+psrc_pkg::SLOT_W-1:0] slot_wide;

   // response register
   logic                          rsp_valid_ff;
   logic [psrc_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [psrc_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic                          rsp_hit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= psrc_pkg::CFG_RESET;
      end else if (csr_valid) begin
         cfg_ff <= csr_entries_in_use;
      end
   end

   // slots in use saturate at the table depth
   always_comb begin
      cfg_wide = NW'(cfg_ff);
      if (cfg_wide > NW'(DEPTH)) begin
         used_in = CW'(DEPTH);
      end else begin
         used_in = CW'(cfg_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         used_ff        <= used_in;
         op_ff          <= req_op;
         item_ff.status <= req_put_status;
         item_ff.address <= req_ip_address;
         item_ff.port   <= req_tcp_port;
         item_ff.kind   <= req_proxy_kind;
         item_ff.stamp  <= req_now_time;
      end
   end

   // scan read issue
   assign issue = cmd.scan && (rd_cnt_ff < used_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         rv_ff      <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            rd_cnt_ff <= '0;
         end else if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + CW'(1);
         end
         rv_ff <= issue;
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      ri_ff <= rd_cnt_ff[IW-1:0];
   end

   assign sts.clear_done = (clr_cnt_ff == IW'(DEPTH - 1));
   assign sts.scan_done  = (rd_cnt_ff >= used_ff) && !rv_ff;
   assign sts.out_busy   = rsp_valid_ff && !rsp_ready;

   // write back: the victim or empty slot for a put, the hit slot for a pick
   always_comb begin
      tgt_idx = all_idx_ff;
      for (int c = NC - 1; c >= 0; c--) begin
         if (cls_found_ff[c]) begin
            tgt_idx = cls_idx_ff[c];
         end
      end
      if (empty_found_ff) begin
         tgt_idx = empty_idx_ff;
      end
      wr_word = item_ff;
      wr_ok   = empty_found_ff || all_found_ff;
      if (op_ff == psrc_pkg::OP_PICK) begin
         tgt_idx       = pick_idx_ff;
         wr_word       = pick_word_ff;
         wr_word.stamp = item_ff.stamp;
         wr_ok         = pick_found_ff;
      end
      slot_wide = (IW + psrc_pkg::SLOT_W)'(tgt_idx);
   end

   always_comb begin
      mem_we = cmd.clear || (cmd.emit && wr_ok);
      mem_wa = cmd.clear ? clr_cnt_ff : tgt_idx;
      mem_wd = cmd.clear ? '0 : wr_word;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_cnt_ff[IW-1:0]];
   end

   // one slot per cycle into the trackers
   always_comb begin
      in_class  = rd_data_ff.status inside {[psrc_pkg::ST_CLOSED:psrc_pkg::ST_TIMEOUT]};
      cls_sel   = in_class ? (rd_data_ff.status - 3'd1) : 3'd0;
      key_match = (rd_data_ff.address == item_ff.address) &&
                  (rd_data_ff.port == item_ff.port) &&
                  (rd_data_ff.kind == item_ff.kind);

      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      all_found_in   = all_found_ff;
      all_idx_in     = all_idx_ff;
      all_time_in    = all_time_ff;
      pick_found_in  = pick_found_ff;
      pick_idx_in    = pick_idx_ff;
      pick_word_in   = pick_word_ff;
      for (int c = 0; c < NC; c++) begin
         cls_found_in[c] = cls_found_ff[c];
         cls_idx_in[c]   = cls_idx_ff[c];
         cls_time_in[c]  = cls_time_ff[c];
      end

      if (cmd.load) begin
         empty_found_in = 1'b0;
         all_found_in   = 1'b0;
         pick_found_in  = 1'b0;
         for (int c = 0; c < NC; c++) begin
            cls_found_in[c] = 1'b0;
         end
      end else if (rv_ff) begin
         if (rd_data_ff.status == psrc_pkg::ST_NONE) begin
            if (!empty_found_ff) begin
               empty_found_in = 1'b1;
               empty_idx_in   = ri_ff;
            end
         end else begin
            // strict compare keeps the lowest index on equal stamps
            if (!all_found_ff || (rd_data_ff.stamp < all_time_ff)) begin
               all_found_in = 1'b1;
               all_idx_in   = ri_ff;
               all_time_in  = rd_data_ff.stamp;
            end
            if (in_class && (!cls_found_ff[cls_sel] ||
                             (rd_data_ff.stamp < cls_time_ff[cls_sel]))) begin
               cls_found_in[cls_sel] = 1'b1;
               cls_idx_in[cls_sel]   = ri_ff;
               cls_time_in[cls_sel]  = rd_data_ff.stamp;
            end
            if (key_match && !pick_found_ff) begin
               pick_found_in = 1'b1;
               pick_idx_in   = ri_ff;
               pick_word_in  = rd_data_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_found_ff <= 1'b0;
         all_found_ff   <= 1'b0;
         pick_found_ff  <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            cls_found_ff[c] <= 1'b0;
         end
      end else begin
         empty_found_ff <= empty_found_in;
         all_found_ff   <= all_found_in;
         pick_found_ff  <= pick_found_in;
         for (int c = 0; c < NC; c++) begin
            cls_found_ff[c] <= cls_found_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      empty_idx_ff <= empty_idx_in;
      all_idx_ff   <= all_idx_in;
      all_time_ff  <= all_time_in;
      pick_idx_ff  <= pick_idx_in;
      pick_word_ff <= pick_word_in;
      for (int c = 0; c < NC; c++) begin
         cls_idx_ff[c]  <= cls_idx_in[c];
         cls_time_ff[c] <= cls_time_in[c];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_hit_ff    <= wr_ok;
         rsp_slot_ff   <= wr_ok ? slot_wide[psrc_pkg::SLOT_W-1:0] : '0;
         rsp_status_ff <= (wr_ok && (op_ff == psrc_pkg::OP_PICK)) ?
                          pick_word_ff.status : psrc_pkg::ST_NONE;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_found_status = rsp_status_ff;

   `PSRC_ASSERT(a_scan_within_used, clock, reset, cmd.scan |-> (rd_cnt_ff <= used_ff))
   `PSRC_ASSERT(a_read_follows_scan, clock, reset, rv_ff |-> $past(cmd.scan))
   `PSRC_ASSERT(a_miss_is_zero, clock, reset,
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_slot_ff == '0 && rsp_status_ff == '0))

endmodule

// ===== hw/rtl/proxy_scan_result_cache.sv =====
// -----------------------------------------------------------------------------
// proxy_scan_result_cache
// fully associative cache of proxy check results keyed by address, port, kind
// -----------------------------------------------------------------------------
//   channel   ports    direction   contents
//   request   req_*    in          op, put_status, ip_address, tcp_port,
//                                  proxy_kind, now_time
//   response  rsp_*    out         found_status, slot, hit
//   csr       csr_*    in          entries_in_use (write only)
//
// an item's scan reads n = min(entries_in_use, DEPTH) slots, one slot per cycle
// through the single memory read port; the chosen slot, if any, is then written
// back and the response register loaded, and only then is the next item accepted.
// after reset a sweep writes zeros to all DEPTH slots of the entry memory; no
// item is accepted until it ends, csr writes are taken throughout.
// a finished response waits in an output register, so the next item is
// accepted while it is pending; a new result stalls until that register frees.
// -----------------------------------------------------------------------------
module proxy_scan_result_cache #(
   parameter int DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psrc_pkg::CFG_W-1:0]      csr_entries_in_use,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [psrc_pkg::STATUS_W-1:0]   req_put_status,
   input  logic [psrc_pkg::ADDR_W-1:0]     req_ip_address,
   input  logic [psrc_pkg::PORT_W-1:0]     req_tcp_port,
   input  logic [psrc_pkg::KIND_W-1:0]     req_proxy_kind,
   input  logic [psrc_pkg::TIME_W-1:0]     req_now_time,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [psrc_pkg::STATUS_W-1:0]   rsp_found_status,
   output logic [psrc_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                            rsp_hit
);

   psrc_pkg::cmd_type cmd;
   psrc_pkg::sts_type sts;

   psrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   psrc_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_entries_in_use (csr_entries_in_use),
      .req_op             (req_op),
      .req_put_status     (req_put_status),
      .req_ip_address     (req_ip_address),
      .req_tcp_port       (req_tcp_port),
      .req_proxy_kind     (req_proxy_kind),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found_status   (rsp_found_status),
      .rsp_slot           (rsp_slot),
      .rsp_hit            (rsp_hit)
   );

endmodule
